>>> design/spf_pkg.sv
// Shared constants of the spline path follower: codes, widths and defaults.
package spf_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 32;

    localparam int CFG_DATA_BITS = 12;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_SPEED_SCALE = 1'b1;

    localparam logic [2:0] STAT_POS    = 3'd0;
    localparam logic [2:0] STAT_END    = 3'd1;
    localparam logic [2:0] STAT_PAUSED = 3'd2;
    localparam logic [2:0] STAT_ACK    = 3'd3;
    localparam logic [2:0] STAT_FEW    = 3'd4;

    localparam logic [6:0]  POINT_COUNT_RST = 7'd0;
    localparam logic [11:0] SPEED_SCALE_RST = 12'd179;

    localparam logic [16:0] PHASE_ONE = 17'h10000;
    localparam logic [16:0] PHASE_MAX = 17'h1FFFF;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INC   = 8'b0000_0010,
        S_PHASE = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_COEF  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } spf_state_t;

endpackage

>>> design/spline_path_follower.sv
// Catmull-Rom path follower with a checkpoint memory and bit-serial multipliers.
// Load and start items pass straight to the result state; an ignored item gives no result.
// A tick with a position runs the serial speed multiply, the phase update, the memory reads,
// the coefficient step, three shift-add passes and the result step.
// Throughput is one item at a time; a new item is taken once the last result is queued.
// Reset leaves the table unwritten, segment 1, phase 0, paused, count 0, speed 179.
module spline_path_follower
    import spf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [5:0]                   point_index,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic [15:0]                  time_step,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   status,
    output logic signed [COORD_BITS-1:0] pos_x,
    output logic signed [COORD_BITS-1:0] pos_y,
    output logic signed [COORD_BITS-1:0] pos_z,
    output logic [5:0]                   segment
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int W  = COORD_BITS + 8;
    localparam int PW = W + 17;

    spf_state_t state_reg, state_next;

    logic [6:0]  point_count_reg;
    logic [11:0] speed_scale_reg;
    logic [CW-1:0] seg_reg;
    logic [16:0] phase_reg;
    logic        paused_reg;

    logic [27:0] inc_mc_reg;
    logic [27:0] inc_acc_reg;
    logic [11:0] inc_mul_reg;
    logic [4:0]  bit_cnt_reg;
    logic [2:0]  rd_cnt_reg;
    logic [1:0]  stage_reg;
    logic [16:0] tr_reg;
    logic [16:0] mplier_reg;
    logic [2:0]  res_status_reg;

    logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
    logic [3*COORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;

    logic [COORD_BITS-1:0] pt_reg [4][3];
    logic signed [W-1:0]   c1_reg [3];
    logic signed [W-1:0]   c2_reg [3];
    logic signed [W-1:0]   p1_reg [3];
    logic signed [PW-1:0]  acc_reg [3];
    logic signed [PW-1:0]  mc_reg [3];
    logic [COORD_BITS-1:0] res_reg [3];

    logic                  out_valid_reg;
    logic [2:0]            status_reg;
    logic [COORD_BITS-1:0] pos_reg [3];
    logic [5:0]            segment_reg;

    logic          in_fire;
    logic          out_free;
    logic [CW-1:0] cnt;
    logic [CW-1:0] last;
    logic [CW-1:0] seg_clamped;
    logic [20:0]   sum;
    logic [20:0]   sum_adj;
    logic          advance;
    logic          reach_end;
    logic [16:0]   phase_new;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign segment   = segment_reg;

    // Phase update of a tick, evaluated in S_PHASE.
    always_comb
    begin
        cnt = (32'(point_count_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count_reg);
        last = cnt - CW'(3);
        seg_clamped = (seg_reg > last) ? last : seg_reg;
        if (seg_clamped == '0)
        begin
            seg_clamped = CW'(1);
        end
        sum = 21'(phase_reg) + 21'(inc_acc_reg[27:8]);
        advance   = (sum >= 21'(PHASE_ONE)) && (seg_clamped < last);
        reach_end = (sum >= 21'(PHASE_ONE)) && !(seg_clamped < last);
        sum_adj   = advance ? (sum - 21'(PHASE_ONE)) : sum;
        phase_new = (sum_adj > 21'(PHASE_MAX)) ? PHASE_MAX : sum_adj[16:0];
    end

    assign rd_addr = AW'(seg_reg - CW'(1) + CW'(rd_cnt_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_LOAD || mode == MODE_START)
                    begin
                        state_next = S_DONE;
                    end
                    else if (mode == MODE_TICK)
                    begin
                        if (cnt < CW'(4) || paused_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INC;
                        end
                    end
                end
            end
            S_INC:
            begin
                if (bit_cnt_reg == 5'd11)
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE: state_next = S_READ;
            S_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = S_COEF;
                end
            end
            S_COEF: state_next = S_MUL;
            S_MUL:
            begin
                if (bit_cnt_reg == 5'd16)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: state_next = (stage_reg == 2'd2) ? S_DONE : S_MUL;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && mode == MODE_LOAD && 32'(point_index) < 32'(MAX_POINTS))
        begin
            mem[AW'(point_index)] <= {point_z, point_y, point_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= POINT_COUNT_RST;
            speed_scale_reg <= SPEED_SCALE_RST;
            seg_reg         <= CW'(1);
            phase_reg       <= '0;
            paused_reg      <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                    REG_SPEED_SCALE: speed_scale_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (in_fire && mode == MODE_START)
            begin
                seg_reg    <= CW'(1);
                paused_reg <= 1'b0;
            end
            if (state_reg == S_PHASE)
            begin
                seg_reg   <= advance ? (seg_clamped + CW'(1)) : seg_clamped;
                phase_reg <= phase_new;
                if (reach_end)
                begin
                    paused_reg <= 1'b1;
                end
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: serial multipliers and coefficient lanes, one lane per axis.
    always_ff @(posedge clk)
    begin
        logic signed [W-1:0] p0, p1, p2, p3, q, fin, r;
        unique case (state_reg)
            S_IDLE:
            begin
                inc_mc_reg  <= 28'(time_step);
                inc_acc_reg <= '0;
                inc_mul_reg <= speed_scale_reg;
                bit_cnt_reg <= '0;
                rd_cnt_reg  <= '0;
                if (mode == MODE_TICK)
                begin
                    res_status_reg <= (cnt < CW'(4)) ? STAT_FEW : STAT_PAUSED;
                end
                else
                begin
                    res_status_reg <= STAT_ACK;
                end
                for (int k = 0; k < 3; k++)
                begin
                    res_reg[k] <= '0;
                end
            end
            S_INC:
            begin
                if (inc_mul_reg[0])
                begin
                    inc_acc_reg <= inc_acc_reg + inc_mc_reg;
                end
                inc_mc_reg  <= inc_mc_reg << 1;
                inc_mul_reg <= inc_mul_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
            S_PHASE:
            begin
                tr_reg         <= (phase_new > PHASE_ONE) ? PHASE_ONE : phase_new;
                res_status_reg <= reach_end ? STAT_END : STAT_POS;
                rd_cnt_reg     <= '0;
            end
            S_READ:
            begin
                // Read data arrives in the cycle after its address.
                if (rd_cnt_reg != 3'd0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pt_reg[2'(rd_cnt_reg - 3'd1)][k] <=
                            rd_data_reg[k*COORD_BITS +: COORD_BITS];
                    end
                end
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
            S_COEF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p0 = W'(signed'(pt_reg[0][k]));
                    p1 = W'(signed'(pt_reg[1][k]));
                    p2 = W'(signed'(pt_reg[2][k]));
                    p3 = W'(signed'(pt_reg[3][k]));
                    c1_reg[k] <= p2 - p0;
                    c2_reg[k] <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
                    mc_reg[k] <= PW'(p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2);
                    p1_reg[k] <= p1;
                    acc_reg[k] <= '0;
                end
                mplier_reg  <= tr_reg;
                bit_cnt_reg <= '0;
                stage_reg   <= '0;
            end
            S_MUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg[k] <= acc_reg[k] + mc_reg[k];
                    end
                    mc_reg[k] <= mc_reg[k] <<< 1;
                end
                mplier_reg  <= mplier_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
            S_NEXT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    q = W'(acc_reg[k] >>> 16);
                    if (stage_reg == 2'd2)
                    begin
                        fin = q + (p1_reg[k] <<< 1);
                        r = fin >>> 1;
                        if (r[W-1:COORD_BITS-1] != {(W-COORD_BITS+1){r[W-1]}})
                        begin
                            res_reg[k] <= r[W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
                        end
                        else
                        begin
                            res_reg[k] <= r[COORD_BITS-1:0];
                        end
                    end
                    else
                    begin
                        mc_reg[k] <= PW'(q + ((stage_reg == 2'd0) ? c2_reg[k] : c1_reg[k]));
                    end
                    acc_reg[k] <= '0;
                end
                mplier_reg  <= tr_reg;
                bit_cnt_reg <= '0;
                stage_reg   <= stage_reg + 2'd1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    status_reg  <= res_status_reg;
                    segment_reg <= 6'(seg_reg);
                    for (int k = 0; k < 3; k++)
                    begin
                        pos_reg[k] <= res_reg[k];
                    end
                end
            end
            default: ;
        endcase
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the completion state");

    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg != '0)
        else $error("segment index fell to zero");

    a_start_unpause: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode == MODE_START |=> !paused_reg && seg_reg == CW'(1))
        else $error("start item did not release the pause");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> bit_cnt_reg <= 5'd16)
        else $error("serial multiply ran past the phase width");

endmodule
